// ----- rtl/psu_pkg.sv -----
// Package: shared types, constants and the predictor function of the scanline unfilter.
`default_nettype none
package psu_pkg;
  localparam int MAX_WIDTH = 4096;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_ALPHA  = 2'd2;

  // One classified pixel handed from front to back.
  typedef struct packed {
    logic             corrupt;
    logic [2:0]       filt;
    logic [31:0]      raw;
    logic             alpha;
    logic [COL_W-1:0] col;
    logic             first_col;
    logic             first_row;
    logic             row_end;
    logic             image_end;
  } psu_job_t;

  function automatic logic [7:0] psu_predict(input logic [2:0] f, input logic [7:0] a,
                                             input logic [7:0] b, input logic [7:0] c);
    logic signed [10:0] th, lo, hi, t0, ia, ib, ic;
    logic [8:0] s;
    ia = {3'b0, a};
    ib = {3'b0, b};
    ic = {3'b0, c};
    th = ic * 11'sd3 - (ia + ib);
    lo = (ia < ib) ? ia : ib;
    hi = (ia < ib) ? ib : ia;
    t0 = (hi <= th) ? lo : ic;
    s = {1'b0, a} + {1'b0, b};
    psu_predict = 8'd0;
    case (f)
      FILT_SUB:   psu_predict = a;
      FILT_UP:    psu_predict = b;
      FILT_AVG:   psu_predict = s[8:1];
      FILT_PAETH: psu_predict = (th <= lo) ? hi[7:0] : t0[7:0];
      default:    psu_predict = 8'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

// ----- rtl/psu_front.sv -----
// Front end: parse filter bytes, gather pixel bytes, track position.
`default_nettype none
module psu_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic [7:0]     in_byte,
  input  wire logic [12:0]    width,
  input  wire logic [15:0]    height,
  input  wire logic           has_alpha,
  output psu_pkg::psu_job_t   job,
  output logic                job_valid
);
  import psu_pkg::*;
  logic [23:0] part_r;
  logic [1:0]  bip_r;
  logic [12:0] col_r;
  logic [15:0] row_r;
  logic [2:0]  filt_r;
  logic        await_r, err_r;
  logic [12:0] w;
  logic [15:0] h;
  logic [1:0]  last_b;
  logic        rend, iend;

  always_comb begin
    w = (width == 13'd0) ? 13'd1 : width;
    if (w > 13'(MAX_WIDTH)) w = 13'(MAX_WIDTH);
    h = (height == 16'd0) ? 16'd1 : height;
    last_b = has_alpha ? 2'd3 : 2'd2;
    rend = (col_r + 13'd1) >= w;
    iend = rend && ({1'b0, row_r} + 17'd1 >= {1'b0, h});
    job = '0;
    job.filt = filt_r;
    job.alpha = has_alpha;
    job.col = (col_r >= 13'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH - 1) : col_r[COL_W-1:0];
    job.first_col = (col_r == 13'd0);
    job.first_row = (row_r == 16'd0);
    job.row_end = rend;
    job.image_end = iend;
    job.raw = {8'd0, part_r};
    if (bip_r == 2'd3) job.raw[31:24] = in_byte;
    else job.raw[{bip_r, 3'b000} +: 8] = in_byte;
    job_valid = 1'b0;
    if (in_valid && !err_r) begin
      if (await_r) begin
        if (in_byte > 8'd4) begin
          job = '0;
          job.corrupt = 1'b1;
          job_valid = 1'b1;
        end
      end else if (bip_r >= last_b) job_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= '0; bip_r <= '0; col_r <= '0; row_r <= '0;
      filt_r <= FILT_NONE; await_r <= 1'b1; err_r <= 1'b0;
    end else if (in_valid && !err_r) begin
      if (await_r) begin
        if (in_byte > 8'd4) err_r <= 1'b1;
        else begin
          filt_r <= in_byte[2:0]; await_r <= 1'b0;
          bip_r <= '0; part_r <= '0; col_r <= '0;
        end
      end else if (bip_r < last_b) begin
        part_r[{bip_r, 3'b000} +: 8] <= in_byte;
        bip_r <= bip_r + 2'd1;
      end else begin
        part_r <= '0; bip_r <= '0;
        if (rend) begin
          col_r <= '0; await_r <= 1'b1;
          row_r <= iend ? 16'd0 : row_r + 16'd1;
        end else col_r <= col_r + 13'd1;
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/psu_queue.sv -----
// Short queue of classified pixels between front and back.
`default_nettype none
module psu_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire psu_pkg::psu_job_t wr_data,
  output logic                   full,
  output logic                   empty,
  input  wire logic              rd_en,
  output psu_pkg::psu_job_t      rd_data
);
  import psu_pkg::*;
  psu_job_t   mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  assign full = cnt_r == 3'd4;
  assign empty = cnt_r == 3'd0;
  assign rd_data = mem_r[rp_r];
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 2'd1;
      if (rd_en) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'b0, wr_en} - {2'b0, rd_en};
    end
  end
endmodule
`default_nettype wire

// ----- rtl/psu_back.sv -----
// Back end: row memory read, predictor, and one-entry result register.
`default_nettype none
module psu_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire psu_pkg::psu_job_t q_data,
  output logic                   q_pop,
  output logic [31:0]            res_px,
  output logic                   res_row_end,
  output logic                   res_image_end,
  output logic                   res_corrupt,
  output logic                   res_valid,
  input  wire logic              res_pop
);
  import psu_pkg::*;
  logic [31:0] row_mem [MAX_WIDTH];
  // stage 1: memory read in flight
  psu_job_t    s1_r;
  logic        s1_v_r;
  logic [31:0] up_r;
  logic [31:0] left_r, ul_r;
  logic [31:0] res_r;
  logic        rv_r, re_r, ie_r, co_r;
  logic        adv, s1_go;
  logic [31:0] pa, pb, pc, px;
  logic        fwd, fwd_r;
  logic [31:0] fwd_px_r;
  logic [31:0] up_eff;

  // stall whole back while result waits
  assign s1_go = s1_v_r && (!rv_r || res_pop);
  assign adv = !s1_v_r || s1_go;
  assign q_pop = adv && !q_empty;
  // a result written in the same cycle to the same column is newer than the read
  assign fwd = s1_go && !s1_r.corrupt && (s1_r.col == q_data.col);
  assign up_eff = fwd_r ? fwd_px_r : up_r;

  always_comb begin
    pa = s1_r.first_col ? 32'd0 : left_r;
    pb = s1_r.first_row ? 32'd0 : up_eff;
    pc = (s1_r.first_col || s1_r.first_row) ? 32'd0 : ul_r;
    for (int k = 0; k < 4; k++)
      px[k*8 +: 8] = s1_r.raw[k*8 +: 8] +
                     psu_predict(s1_r.filt, pa[k*8 +: 8], pb[k*8 +: 8], pc[k*8 +: 8]);
    if (!s1_r.alpha) px[31:24] = 8'hFF;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_r <= q_data;
      up_r <= row_mem[q_data.col];
      fwd_r <= fwd;
      fwd_px_r <= px;
    end
    if (s1_go && !s1_r.corrupt) begin
      row_mem[s1_r.col] <= px;
      left_r <= px;
      ul_r <= up_eff;
    end
    if (s1_go) begin
      res_r <= s1_r.corrupt ? 32'd0 : px;
      re_r <= s1_r.row_end && !s1_r.corrupt;
      ie_r <= s1_r.image_end && !s1_r.corrupt;
      co_r <= s1_r.corrupt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; rv_r <= 1'b0;
    end else begin
      if (adv) s1_v_r <= q_pop;
      if (s1_go) rv_r <= 1'b1;
      else if (res_pop) rv_r <= 1'b0;
    end
  end

  assign res_px = res_r;
  assign res_row_end = re_r;
  assign res_image_end = ie_r;
  assign res_corrupt = co_r;
  assign res_valid = rv_r;
endmodule
`default_nettype wire

// ----- rtl/png_scanline_unfilter.sv -----
// Top level of the PNG scanline unfilter for 8-bit RGB and RGBA images.
`default_nettype none
// Accepts one inflated scanline byte per cycle while in_full is low (filter byte,
// then channel bytes) and emits one reconstructed B,G,R,A pixel per completed
// pixel, alpha 255 for RGB. Throughput is one byte per cycle unless in_full holds
// the input; once its last byte is accepted, a pixel reaches the out_ ports through
// the queue entry, the registered row-memory read and the registered result word.
// A four-entry queue splits the byte parser from the filter engine. A filter byte
// above 4 yields one word with out_corrupt high and the block then drops all input
// until reset. Write configuration only while idle; the row memory needs no clearing after reset.
module png_scanline_unfilter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_green,
  output logic [7:0]       out_red,
  output logic [7:0]       out_alpha,
  output logic             out_row_end,
  output logic             out_image_end,
  output logic             out_corrupt,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import psu_pkg::*;
  logic [12:0] width_r;
  logic [15:0] height_r;
  logic        alpha_r;
  psu_job_t    job, q_data;
  logic        job_valid, q_full, q_empty, q_pop, res_valid;
  logic [31:0] px;
  logic        acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 13'd1; height_r <= 16'd1; alpha_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r <= cfg_data[12:0];
        CFG_HEIGHT: height_r <= cfg_data;
        CFG_ALPHA:  alpha_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // accept only when the queue has room for a possible pixel word
  assign in_full = q_full;
  assign acc = in_push && !q_full;

  psu_front u_front (.clk, .rst_n, .in_valid(acc), .in_byte(in_data_byte),
    .width(width_r), .height(height_r), .has_alpha(alpha_r), .job, .job_valid);

  psu_queue u_queue (.clk, .rst_n, .wr_en(job_valid), .wr_data(job), .full(q_full),
    .empty(q_empty), .rd_en(q_pop), .rd_data(q_data));

  psu_back u_back (.clk, .rst_n, .q_empty, .q_data, .q_pop, .res_px(px),
    .res_row_end(out_row_end), .res_image_end(out_image_end),
    .res_corrupt(out_corrupt), .res_valid, .res_pop(out_pop && res_valid));

  assign out_empty = !res_valid;
  assign out_blue = px[23:16];
  assign out_green = px[15:8];
  assign out_red = px[7:0];
  assign out_alpha = px[31:24];

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !job_valid) else $error("queue overflow");
  a_corrupt_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_corrupt) |-> (!out_row_end && px == 32'd0))
    else $error("corrupt word carries pixel data");
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(px)))
    else $error("result word changed while waiting");
endmodule
`default_nettype wire
